FILE: sv/irc_tok_pkg.sv
// Shared types and constants for the IRC line tokenizer.
// Holds the result codes, the character constants and the command word passed front to back.
`timescale 1ns / 1ps
`default_nettype none

package irc_tok_pkg;

  localparam int MAX_PARAMS_DEF  = 15;
  localparam int PENDING_MAX_DEF = 8;
  // widest held CR/LF run any configuration can store
  localparam int PEND_CAP        = 15;
  localparam int Q_DEPTH         = 4;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_CLOSE = 2'd1;
  localparam logic [1:0] K_DONE  = 2'd2;

  localparam logic [1:0] F_PFX = 2'd0;
  localparam logic [1:0] F_CMD = 2'd1;
  localparam logic [1:0] F_MID = 2'd2;
  localparam logic [1:0] F_TRL = 2'd3;

  // Everything one accepted word asks the back end to emit, in this order:
  // released CR/LF run, field byte, field close, line finished.
  typedef struct packed {
    logic [3:0]          rel_len;
    logic [PEND_CAP-1:0] rel_kinds;
    logic                byte_en;
    logic [1:0]          byte_field;
    logic [3:0]          byte_idx;
    logic [7:0]          byte_val;
    logic                close_en;
    logic [1:0]          close_field;
    logic [3:0]          close_idx;
    logic                done_en;
    logic [3:0]          total;
    logic                ovf;
  } cmd_t;

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h61:8'h7a]}) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/irc_tok_if.sv
// Valid/ready channel interfaces for the IRC line tokenizer.
// One interface for incoming line words, one for result words; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface irc_tok_in_if;
  logic       valid;
  logic       ready;
  logic       has_byte;
  logic [7:0] data_byte;
  logic       line_end;

  modport source (output valid, has_byte, data_byte, line_end, input ready);
  modport sink   (input valid, has_byte, data_byte, line_end, output ready);
endinterface

interface irc_tok_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] field;
  logic [3:0] param_index;
  logic [7:0] out_byte;
  logic [3:0] param_total;
  logic       run_overflow;
  logic       last;

  modport source (output valid, kind, field, param_index, out_byte, param_total,
                  run_overflow, last, input ready);
  modport sink   (input valid, kind, field, param_index, out_byte, param_total,
                  run_overflow, last, output ready);
endinterface

`default_nettype wire

FILE: sv/irc_tok_front.sv
// Front end: accepts line words, tracks the field parser and the held CR/LF run.
// Produces at most one command word per accepted input; depends on irc_tok_pkg and irc_tok_if.
`timescale 1ns / 1ps
`default_nettype none

module irc_tok_front #(
  parameter int MAX_PARAMS  = irc_tok_pkg::MAX_PARAMS_DEF,
  parameter int PENDING_MAX = irc_tok_pkg::PENDING_MAX_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  irc_tok_in_if.sink        rx,
  input  wire logic         q_full,
  output irc_tok_pkg::cmd_t cmd,
  output logic              cmd_push
);
  import irc_tok_pkg::*;

  localparam logic [3:0] PH_START    = 4'd0;
  localparam logic [3:0] PH_PFX_SKIP = 4'd1;
  localparam logic [3:0] PH_PFX_WORD = 4'd2;
  localparam logic [3:0] PH_PFX_REST = 4'd3;
  localparam logic [3:0] PH_CMD_SKIP = 4'd4;
  localparam logic [3:0] PH_CMD_WORD = 4'd5;
  localparam logic [3:0] PH_CMD_REST = 4'd6;
  localparam logic [3:0] PH_PAR_SKIP = 4'd7;
  localparam logic [3:0] PH_MID      = 4'd8;
  localparam logic [3:0] PH_TRAIL    = 4'd9;
  localparam logic [3:0] PH_IGNORE   = 4'd10;

  localparam logic [3:0] MAXP = 4'(MAX_PARAMS);
  localparam logic [3:0] PMAX = 4'(PENDING_MAX);

  logic [3:0]             phase, phase_next;
  logic [3:0]             param_cnt, param_cnt_next;
  logic [3:0]             held_len, held_len_next;
  logic                   ovf, ovf_next;
  logic [PENDING_MAX-1:0] held_kinds;
  logic                   wr_en;
  logic                   wr_lf;
  logic                   accept;
  logic [7:0]             c;

  assign rx.ready = !q_full;
  assign accept   = rx.valid && rx.ready;
  assign c        = rx.data_byte;

  always_comb begin
    phase_next     = phase;
    param_cnt_next = param_cnt;
    held_len_next  = held_len;
    ovf_next       = ovf;
    wr_en          = 1'b0;
    wr_lf          = 1'b0;
    cmd            = '0;
    cmd.rel_kinds  = PEND_CAP'(held_kinds);

    if (rx.has_byte) begin
      case (phase)
        PH_START, PH_CMD_SKIP: begin
          if (phase == PH_START && c == CH_COLON) begin
            phase_next = PH_PFX_SKIP;
          end else if (c == CH_SPACE) begin
            phase_next = PH_CMD_SKIP;
          end else if (c == CH_COLON) begin
            phase_next = PH_CMD_REST;
          end else begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_CMD;
            cmd.byte_val   = upcase(c);
            phase_next     = PH_CMD_WORD;
          end
        end
        PH_PFX_SKIP: begin
          if (c == CH_COLON) begin
            phase_next = PH_PFX_REST;
          end else if (c != CH_SPACE) begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_PFX;
            cmd.byte_val   = c;
            phase_next     = PH_PFX_WORD;
          end
        end
        PH_PFX_WORD: begin
          if (c == CH_SPACE) begin
            cmd.close_en    = 1'b1;
            cmd.close_field = F_PFX;
            phase_next      = PH_CMD_SKIP;
          end else begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_PFX;
            cmd.byte_val   = c;
          end
        end
        PH_PFX_REST: begin
          cmd.byte_en    = 1'b1;
          cmd.byte_field = F_PFX;
          cmd.byte_val   = c;
        end
        PH_CMD_WORD: begin
          if (c == CH_SPACE) begin
            cmd.close_en    = 1'b1;
            cmd.close_field = F_CMD;
            phase_next      = PH_PAR_SKIP;
          end else begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_CMD;
            cmd.byte_val   = upcase(c);
          end
        end
        PH_CMD_REST: begin
          cmd.byte_en    = 1'b1;
          cmd.byte_field = F_CMD;
          cmd.byte_val   = upcase(c);
        end
        PH_PAR_SKIP: begin
          if (c == CH_COLON) begin
            phase_next    = PH_TRAIL;
            held_len_next = '0;
          end else if (c != CH_SPACE) begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_MID;
            cmd.byte_idx   = param_cnt;
            cmd.byte_val   = c;
            phase_next     = PH_MID;
          end
        end
        PH_MID: begin
          if (c == CH_SPACE) begin
            cmd.close_en    = 1'b1;
            cmd.close_field = F_MID;
            cmd.close_idx   = param_cnt;
            param_cnt_next  = param_cnt + 4'd1;
            phase_next      = (param_cnt_next >= MAXP) ? PH_IGNORE : PH_PAR_SKIP;
          end else begin
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_MID;
            cmd.byte_idx   = param_cnt;
            cmd.byte_val   = c;
          end
        end
        PH_TRAIL: begin
          if (c == CH_CR || c == CH_LF) begin
            // hold the run back; past the store depth only flag it
            if (held_len < PMAX) begin
              wr_en         = 1'b1;
              wr_lf         = (c == CH_LF);
              held_len_next = held_len + 4'd1;
            end else begin
              ovf_next = 1'b1;
            end
          end else begin
            cmd.rel_len    = held_len;
            cmd.byte_en    = 1'b1;
            cmd.byte_field = F_TRL;
            cmd.byte_idx   = param_cnt;
            cmd.byte_val   = c;
            held_len_next  = '0;
          end
        end
        default: begin
        end
      endcase
    end

    if (rx.line_end) begin
      case (phase_next)
        PH_PFX_SKIP, PH_PFX_WORD, PH_PFX_REST: begin
          cmd.close_en    = 1'b1;
          cmd.close_field = F_PFX;
        end
        PH_CMD_WORD, PH_CMD_REST: begin
          cmd.close_en    = 1'b1;
          cmd.close_field = F_CMD;
        end
        PH_MID: begin
          cmd.close_en    = 1'b1;
          cmd.close_field = F_MID;
          cmd.close_idx   = param_cnt;
          param_cnt_next  = param_cnt_next + 4'd1;
        end
        PH_TRAIL: begin
          cmd.close_en    = 1'b1;
          cmd.close_field = F_TRL;
          cmd.close_idx   = param_cnt;
          param_cnt_next  = param_cnt_next + 4'd1;
        end
        default: begin
        end
      endcase
      cmd.done_en    = 1'b1;
      cmd.total      = param_cnt_next;
      cmd.ovf        = ovf_next;
      phase_next     = PH_START;
      param_cnt_next = '0;
      held_len_next  = '0;
      ovf_next       = 1'b0;
    end

    cmd_push = accept && (cmd.byte_en || cmd.close_en || cmd.done_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      param_cnt <= '0;
      held_len  <= '0;
      ovf       <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      param_cnt <= param_cnt_next;
      held_len  <= held_len_next;
      ovf       <= ovf_next;
    end
  end

  // run store: no reset, only entries below held_len are ever read
  always_ff @(posedge clk) begin
    for (int k = 0; k < PENDING_MAX; k++) begin
      if (accept && wr_en && held_len == 4'(k)) begin
        held_kinds[k] <= wr_lf;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/irc_tok_queue.sv
// Short command queue between the tokenizer front and back ends.
// Register FIFO of cmd_t words; depends on irc_tok_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irc_tok_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  irc_tok_pkg::cmd_t din,
  input  wire logic         pop,
  output irc_tok_pkg::cmd_t dout,
  output logic              full,
  output logic              empty
);
  import irc_tok_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  cmd_t        mem [Q_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full  = (count == (PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: sv/irc_tok_back.sv
// Back end: expands each queued command into result words, one per cycle while tx is ready.
// Drives the registered result channel; depends on irc_tok_pkg and irc_tok_if.
`timescale 1ns / 1ps
`default_nettype none

module irc_tok_back (
  input  wire logic         clk,
  input  wire logic         rst,
  input  irc_tok_pkg::cmd_t head,
  input  wire logic         q_empty,
  output logic              q_pop,
  irc_tok_out_if.source     tx
);
  import irc_tok_pkg::*;

  logic [3:0] rel_pos;
  logic       byte_sent;
  logic       close_sent;
  logic       rel_act;
  logic       byte_act;
  logic       close_act;
  logic       load;
  logic       fire;
  logic       res_last;
  logic [1:0] r_kind;
  logic [1:0] r_field;
  logic [3:0] r_idx;
  logic [7:0] r_byte;

  assign rel_act   = rel_pos < head.rel_len;
  assign byte_act  = head.byte_en && !byte_sent;
  assign close_act = head.close_en && !close_sent;
  assign load      = !tx.valid || tx.ready;
  assign fire      = load && !q_empty;
  assign q_pop     = fire && res_last;

  always_comb begin
    r_kind   = K_DONE;
    r_field  = F_PFX;
    r_idx    = '0;
    r_byte   = '0;
    res_last = 1'b1;
    if (rel_act) begin
      r_kind   = K_BYTE;
      r_field  = F_TRL;
      r_idx    = head.byte_idx;
      r_byte   = head.rel_kinds[rel_pos] ? CH_LF : CH_CR;
      res_last = !((5'(rel_pos) + 5'd1 < 5'(head.rel_len)) || head.byte_en ||
                   head.close_en || head.done_en);
    end else if (byte_act) begin
      r_kind   = K_BYTE;
      r_field  = head.byte_field;
      r_idx    = head.byte_idx;
      r_byte   = head.byte_val;
      res_last = !(head.close_en || head.done_en);
    end else if (close_act) begin
      r_kind   = K_CLOSE;
      r_field  = head.close_field;
      r_idx    = head.close_idx;
      res_last = !head.done_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid   <= 1'b0;
      rel_pos    <= '0;
      byte_sent  <= 1'b0;
      close_sent <= 1'b0;
    end else if (load) begin
      tx.valid <= !q_empty;
      if (fire) begin
        if (res_last) begin
          rel_pos    <= '0;
          byte_sent  <= 1'b0;
          close_sent <= 1'b0;
        end else if (rel_act) begin
          rel_pos <= rel_pos + 4'd1;
        end else if (byte_act) begin
          byte_sent <= 1'b1;
        end else begin
          close_sent <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx.kind         <= r_kind;
      tx.field        <= r_field;
      tx.param_index  <= r_idx;
      tx.out_byte     <= r_byte;
      tx.param_total  <= (r_kind == K_DONE) ? head.total : 4'd0;
      tx.run_overflow <= (r_kind == K_DONE) && head.ovf;
      tx.last         <= res_last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/irc_line_tokenizer.sv
// Top level of the IRC line tokenizer: front end, command queue, back end.
// Depends on irc_tok_pkg, irc_tok_if, irc_tok_front, irc_tok_queue and irc_tok_back.
//
// Splits one IRC line, fed a word at a time on rx, into prefix, command and
// parameter fields and emits tagged result words on tx. The front end takes
// one input word per cycle whenever the four-entry command queue has room;
// the back end sends one result word per cycle from a registered output while tx
// is ready, so a word that gives n results holds the back end until all n are sent
// (n is at most PENDING_MAX + 3, when a full held CR/LF run is released at the end
// of a line). Lines in which each word gives at most one result run at one word
// per cycle while tx is ready. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module irc_line_tokenizer #(
  parameter int MAX_PARAMS  = irc_tok_pkg::MAX_PARAMS_DEF,
  parameter int PENDING_MAX = irc_tok_pkg::PENDING_MAX_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  irc_tok_in_if.sink    rx,
  irc_tok_out_if.source tx
);
  import irc_tok_pkg::*;

  cmd_t cmd;
  cmd_t head;
  logic cmd_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  irc_tok_front #(
    .MAX_PARAMS  (MAX_PARAMS),
    .PENDING_MAX (PENDING_MAX)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .rx       (rx),
    .q_full   (q_full),
    .cmd      (cmd),
    .cmd_push (cmd_push)
  );

  irc_tok_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd),
    .pop   (q_pop),
    .dout  (head),
    .full  (q_full),
    .empty (q_empty)
  );

  irc_tok_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .tx      (tx)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !q_full)
    else $error("command pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("command popped from an empty queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind == K_DONE |-> tx.last)
    else $error("line finished word not marked last");

  a_totals_only_on_done: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.kind != K_DONE |-> tx.param_total == 4'd0 && !tx.run_overflow)
    else $error("totals set on a word other than line finished");

endmodule

`default_nettype wire
